// File: hw/rtl/ramped_pi_speed_loop_feedforward_macros.svh
// Assertion shorthands used by the checker file.
`ifndef RAMPED_PI_SPEED_LOOP_FEEDFORWARD_MACROS_SVH
`define RAMPED_PI_SPEED_LOOP_FEEDFORWARD_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that holds at every edge out of reset.
`define CHK_HOLD(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

// File: hw/rtl/rpsl_pkg.sv
`default_nettype none

package rpsl_pkg;

	// Channel count and field widths
	localparam int MOTORS     = 4;
	localparam int MOTOR_W    = 2;
	localparam int RPM_W      = 14;
	localparam int ERR_W      = RPM_W + 1;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 16;
	localparam int CNT_W      = 8;
	localparam int INTEG_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_W     = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_FF_GAIN        = 3'd2,
		REG_START_OFFSET   = 3'd3,
		REG_RAMP_STEP      = 3'd4,
		REG_MAX_DRIVE      = 3'd5,
		REG_ERROR_LIMIT    = 3'd6,
		REG_OVERLOAD_TICKS = 3'd7
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN      = 16'd256;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN     = 16'd0;
	localparam logic [GAIN_W-1:0]  RST_FF_GAIN        = 16'd0;
	localparam logic [DRIVE_W-1:0] RST_START_OFFSET   = 16'd0;
	localparam logic [RPM_W-1:0]   RST_RAMP_STEP      = 14'd10;
	localparam logic [DRIVE_W-1:0] RST_MAX_DRIVE      = 16'd1000;
	localparam logic [RPM_W-1:0]   RST_ERROR_LIMIT    = 14'd300;
	localparam logic [CNT_W-1:0]   RST_OVERLOAD_TICKS = 8'd20;

endpackage

`default_nettype wire

// File: hw/rtl/rpsl_ifs.sv
`default_nettype none

// Control tick channel
interface rpsl_in_if;
	logic                          valid;
	logic                          ready;
	logic [rpsl_pkg::MOTOR_W-1:0]  motor_select;
	logic [rpsl_pkg::RPM_W-1:0]    measured_rpm;
	logic [rpsl_pkg::RPM_W-1:0]    set_rpm;
	logic                          ramp_up;

	modport source (output valid, motor_select, measured_rpm, set_rpm, ramp_up, input ready);
	modport sink (input valid, motor_select, measured_rpm, set_rpm, ramp_up, output ready);
endinterface

// Result channel
interface rpsl_out_if;
	logic                              valid;
	logic                              ready;
	logic [rpsl_pkg::MOTOR_W-1:0]      motor_echo;
	logic [rpsl_pkg::DRIVE_W-1:0]      drive_value;
	logic [rpsl_pkg::RPM_W-1:0]        target_rpm;
	logic signed [rpsl_pkg::ERR_W-1:0] speed_error;
	logic                              rpm_fault;

	modport source (output valid, motor_echo, drive_value, target_rpm, speed_error, rpm_fault,
		input ready);
	modport sink (input valid, motor_echo, drive_value, target_rpm, speed_error, rpm_fault,
		output ready);
endinterface

// Configuration write channel
interface rpsl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rpsl_pkg::CFG_IDX_W-1:0]   index;
	logic [rpsl_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ramped_pi_speed_loop_feedforward.sv
// Channel   Dir  Payload                                                   Accepted when
// tick      in   motor_select, measured_rpm, set_rpm, ramp_up              valid & ready
// result    out  motor_echo, drive_value, target_rpm, speed_error, fault   valid & ready
// cfg       in   index, data                                               valid & ready
//
// One item per cycle sustained while the result channel is not stalled; an accepted item goes
// to the input register, then through one pass of ramp, PI and clamp logic into the result.
// Per-motor state is read and written in the same cycle that an item moves to the result
// register, so back-to-back items for the same motor see each other's updates.
// The result register and the input register each hold one item: a stalled result
// channel lets one more item in, then ready drops. cfg is always ready.
// arst_n clears valid flags, configuration to its defaults and all per-motor state.
`default_nettype none

module ramped_pi_speed_loop_feedforward (
	input  wire           clk,
	input  wire           arst_n,
	rpsl_in_if.sink       tick,
	rpsl_out_if.source    result,
	rpsl_cfg_if.sink      cfg
);

	localparam int RPM_W   = rpsl_pkg::RPM_W;
	localparam int ERR_W   = rpsl_pkg::ERR_W;
	localparam int INTEG_W = rpsl_pkg::INTEG_W;
	localparam int DRIVE_W = rpsl_pkg::DRIVE_W;
	localparam int GAIN_W  = rpsl_pkg::GAIN_W;
	localparam int CNT_W   = rpsl_pkg::CNT_W;
	localparam int FRAC_W  = rpsl_pkg::FRAC_W;
	localparam int MOTORS  = rpsl_pkg::MOTORS;
	localparam int P_W     = GAIN_W + 1 + ERR_W;
	localparam int I_W     = GAIN_W + 1 + INTEG_W;
	localparam int FF_W    = RPM_W + GAIN_W;
	localparam int TOT_W   = I_W + 1;
	localparam int FLR_W   = TOT_W - FRAC_W;

	// Configuration registers
	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, ff_gain_q;
	logic [DRIVE_W-1:0] start_offset_q, max_drive_q;
	logic [RPM_W-1:0]   ramp_step_q, error_limit_q;
	logic [CNT_W-1:0]   overload_ticks_q;

	// Per-motor state
	logic [RPM_W-1:0]          target_q   [MOTORS];
	logic signed [INTEG_W-1:0] integral_q [MOTORS];
	logic [CNT_W-1:0]          overload_q [MOTORS];
	logic                      windup_q   [MOTORS];
	logic                      fault_q;

	// Input register
	logic                          vld_s1;
	logic [rpsl_pkg::MOTOR_W-1:0]  motor_s1;
	logic [RPM_W-1:0]              meas_s1, set_s1;
	logic                          up_s1;

	// Result register
	logic                          vld_s2;
	logic [rpsl_pkg::MOTOR_W-1:0]  motor_s2;
	logic [DRIVE_W-1:0]            drive_s2;
	logic [RPM_W-1:0]              target_s2;
	logic signed [ERR_W-1:0]       error_s2;
	logic                          fault_s2;

	logic advance, motor_ok;

	// Datapath nets
	logic [RPM_W-1:0]          tgt_old, tgt_new;
	logic [RPM_W:0]            up_sum;
	logic signed [RPM_W+1:0]   dn_diff;
	logic signed [ERR_W-1:0]   err, err_neg;
	logic [RPM_W-1:0]          err_mag;
	logic [CNT_W-1:0]          cnt_inc, cnt_new;
	logic                      raise;
	logic signed [INTEG_W-1:0] integ_old, integ_new;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [P_W-1:0]     p_prod;
	logic signed [I_W-1:0]     i_prod;
	logic [FF_W-1:0]           ff_prod;
	logic signed [TOT_W-1:0]   total, limit;
	logic signed [FLR_W-1:0]   drv_floor;
	logic                      windup_new;
	logic [DRIVE_W-1:0]        drive_raw, drive_new;

	// Handshake: the input register moves on when the result register is free or being taken
	assign advance    = vld_s1 && (!vld_s2 || result.ready);
	assign tick.ready = !vld_s1 || advance;
	assign cfg.ready  = 1'b1;
	assign motor_ok   = (32'(motor_s1) < MOTORS);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= rpsl_pkg::RST_PROP_GAIN;
			integ_gain_q     <= rpsl_pkg::RST_INTEG_GAIN;
			ff_gain_q        <= rpsl_pkg::RST_FF_GAIN;
			start_offset_q   <= rpsl_pkg::RST_START_OFFSET;
			ramp_step_q      <= rpsl_pkg::RST_RAMP_STEP;
			max_drive_q      <= rpsl_pkg::RST_MAX_DRIVE;
			error_limit_q    <= rpsl_pkg::RST_ERROR_LIMIT;
			overload_ticks_q <= rpsl_pkg::RST_OVERLOAD_TICKS;
		end else if (cfg.valid) begin
			case (rpsl_pkg::cfg_reg_t'(cfg.index))
				rpsl_pkg::REG_PROP_GAIN:      prop_gain_q      <= cfg.data;
				rpsl_pkg::REG_INTEG_GAIN:     integ_gain_q     <= cfg.data;
				rpsl_pkg::REG_FF_GAIN:        ff_gain_q        <= cfg.data;
				rpsl_pkg::REG_START_OFFSET:   start_offset_q   <= cfg.data;
				rpsl_pkg::REG_RAMP_STEP:      ramp_step_q      <= cfg.data[RPM_W-1:0];
				rpsl_pkg::REG_MAX_DRIVE:      max_drive_q      <= cfg.data;
				rpsl_pkg::REG_ERROR_LIMIT:    error_limit_q    <= cfg.data[RPM_W-1:0];
				rpsl_pkg::REG_OVERLOAD_TICKS: overload_ticks_q <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			motor_s1 <= tick.motor_select;
			meas_s1  <= tick.measured_rpm;
			set_s1   <= tick.set_rpm;
			up_s1    <= tick.ramp_up;
		end
	end

	// Ramp step of the target
	always_comb begin
		tgt_old = target_q[motor_s1];
		up_sum  = {1'b0, tgt_old} + {1'b0, ramp_step_q};
		dn_diff = $signed({2'b00, tgt_old}) - $signed({2'b00, ramp_step_q});
		tgt_new = tgt_old;
		if (up_s1) begin
			if (tgt_old != set_s1) begin
				tgt_new = (up_sum > {1'b0, set_s1}) ? set_s1 : up_sum[RPM_W-1:0];
			end
		end else if (tgt_old != '0) begin
			tgt_new = (dn_diff <= $signed({2'b00, ramp_step_q})) ? '0 : dn_diff[RPM_W-1:0];
		end
	end

	// Error and overload count
	always_comb begin
		err     = $signed({1'b0, tgt_new}) - $signed({1'b0, meas_s1});
		err_neg = -err;
		err_mag = err[ERR_W-1] ? err_neg[RPM_W-1:0] : err[RPM_W-1:0];
		cnt_inc = overload_q[motor_s1] + 1'b1;
		raise   = 1'b0;
		cnt_new = '0;
		if (err_mag >= error_limit_q) begin
			if (cnt_inc >= overload_ticks_q) begin
				raise = 1'b1;
			end else begin
				cnt_new = cnt_inc;
			end
		end
	end

	// Integral, frozen while the last output of this motor saturated
	always_comb begin
		integ_old = integral_q[motor_s1];
		integ_sum = {integ_old[INTEG_W-1], integ_old} +
			{{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
		case (integ_sum[INTEG_W:INTEG_W-1])
			2'b01:   integ_new = {1'b0, {(INTEG_W-1){1'b1}}};
			2'b10:   integ_new = {1'b1, {(INTEG_W-1){1'b0}}};
			default: integ_new = integ_sum[INTEG_W-1:0];
		endcase
		if (windup_q[motor_s1]) begin
			integ_new = integ_old;
		end
	end

	// PI sum with feedforward, saturation and floor
	always_comb begin
		p_prod  = $signed({1'b0, prop_gain_q}) * err;
		i_prod  = $signed({1'b0, integ_gain_q}) * integ_new;
		ff_prod = FF_W'(tgt_new) * FF_W'(ff_gain_q);
		total   = $signed({{(TOT_W-DRIVE_W-FRAC_W){1'b0}}, start_offset_q, {FRAC_W{1'b0}}})
			+ {{(TOT_W-P_W){p_prod[P_W-1]}}, p_prod}
			+ {{(TOT_W-I_W){i_prod[I_W-1]}}, i_prod}
			+ $signed({{(TOT_W-DRIVE_W-FRAC_W){1'b0}},
				ff_prod[FRAC_W+DRIVE_W-1:FRAC_W], {FRAC_W{1'b0}}});
		limit   = $signed({{(TOT_W-DRIVE_W-FRAC_W){1'b0}}, max_drive_q, {FRAC_W{1'b0}}});
		drv_floor  = total[TOT_W-1:FRAC_W];
		windup_new = (total > limit);
		drive_raw  = windup_new ? max_drive_q : drv_floor[DRIVE_W-1:0];
		if (!windup_new && drv_floor < $signed({{(FLR_W-DRIVE_W){1'b0}}, start_offset_q})) begin
			drive_new = start_offset_q;
		end else if (drive_raw < start_offset_q) begin
			drive_new = start_offset_q;
		end else begin
			drive_new = drive_raw;
		end
	end

	// Write back per-motor state as the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTORS; i++) begin
				target_q[i]   <= '0;
				integral_q[i] <= '0;
				overload_q[i] <= '0;
				windup_q[i]   <= 1'b0;
			end
			fault_q <= 1'b0;
		end else if (advance && motor_ok) begin
			target_q[motor_s1]   <= tgt_new;
			integral_q[motor_s1] <= integ_new;
			overload_q[motor_s1] <= cnt_new;
			windup_q[motor_s1]   <= windup_new;
			fault_q              <= fault_q | raise;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (result.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			motor_s2 <= motor_s1;
			if (motor_ok) begin
				drive_s2  <= drive_new;
				target_s2 <= tgt_new;
				error_s2  <= err;
				fault_s2  <= fault_q | raise;
			end else begin
				drive_s2  <= '0;
				target_s2 <= '0;
				error_s2  <= '0;
				fault_s2  <= fault_q;
			end
		end
	end

	assign result.valid       = vld_s2;
	assign result.motor_echo  = motor_s2;
	assign result.drive_value = drive_s2;
	assign result.target_rpm  = target_s2;
	assign result.speed_error = error_s2;
	assign result.rpm_fault   = fault_s2;

endmodule

`default_nettype wire

// File: hw/rtl/rpsl_checker.sv
`default_nettype none
`include "ramped_pi_speed_loop_feedforward_macros.svh"

module rpsl_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                tick_valid,
	input wire                                tick_ready,
	input wire                                res_valid,
	input wire                                res_ready,
	input wire [rpsl_pkg::MOTOR_W-1:0]        res_motor,
	input wire [rpsl_pkg::DRIVE_W-1:0]        res_drive,
	input wire [rpsl_pkg::RPM_W-1:0]          res_target,
	input wire                                res_fault,
	input wire                                cfg_valid,
	input wire                                cfg_ready,
	input wire [rpsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input wire [rpsl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [1:0]                   pend_q;
	logic                         fault_seen_q;
	logic [rpsl_pkg::DRIVE_W-1:0] start_sh_q, max_sh_q;
	logic                         tick_acc, res_acc;

	assign tick_acc = tick_valid && tick_ready;
	assign res_acc  = res_valid && res_ready;

	// Track items in flight, the fault once delivered, and the drive limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			fault_seen_q <= 1'b0;
			start_sh_q   <= rpsl_pkg::RST_START_OFFSET;
			max_sh_q     <= rpsl_pkg::RST_MAX_DRIVE;
		end else begin
			pend_q <= pend_q + {1'b0, tick_acc} - {1'b0, res_acc};
			if (res_acc && res_fault) begin
				fault_seen_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready && cfg_index == rpsl_pkg::REG_START_OFFSET) begin
				start_sh_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == rpsl_pkg::REG_MAX_DRIVE) begin
				max_sh_q <= cfg_data;
			end
		end
	end

	`CHK_HOLD(a_pend_bound, clk, arst_n, pend_q <= 2'd2, "more than two items in flight")
	`CHK_IMPLY(a_no_phantom, clk, arst_n, res_valid, pend_q != 2'd0, "result without an item")
	`CHK_IMPLY(a_fault_sticky, clk, arst_n, res_valid && fault_seen_q, res_fault, "fault cleared")
	`CHK_IMPLY(a_drive_range, clk, arst_n, res_valid, (res_drive >= start_sh_q) && ((res_drive <= max_sh_q) || (res_drive == start_sh_q)), "drive out of range")
	`CHK_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_drive) && $stable(res_motor) && $stable(res_target), "stalled result changed")

endmodule

bind ramped_pi_speed_loop_feedforward rpsl_checker u_rpsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_motor  (result.motor_echo),
	.res_drive  (result.drive_value),
	.res_target (result.target_rpm),
	.res_fault  (result.rpm_fault),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.cfg_index  (cfg.index),
	.cfg_data   (cfg.data)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rpsl_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		logic [MOTOR_W-1:0] motor;
		logic [RPM_W-1:0]   meas;
		logic [RPM_W-1:0]   set;
		logic               up;
	} tick_t;

	typedef struct {
		logic [MOTOR_W-1:0]      motor;
		logic [DRIVE_W-1:0]      drive;
		logic [RPM_W-1:0]        target;
		logic signed [ERR_W-1:0] err;
		logic                    fault;
	} loop_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rpsl_in_if  tick_if ();
	rpsl_out_if res_if ();
	rpsl_cfg_if cfg_if ();

	ramped_pi_speed_loop_feedforward dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Loop settings as seen by the block
	logic [GAIN_W-1:0]  kp     = RST_PROP_GAIN;
	logic [GAIN_W-1:0]  ki     = RST_INTEG_GAIN;
	logic [GAIN_W-1:0]  kff    = RST_FF_GAIN;
	logic [DRIVE_W-1:0] offs   = RST_START_OFFSET;
	logic [RPM_W-1:0]   rstep  = RST_RAMP_STEP;
	logic [DRIVE_W-1:0] mxd    = RST_MAX_DRIVE;
	logic [RPM_W-1:0]   elim   = RST_ERROR_LIMIT;
	logic [CNT_W-1:0]   oticks = RST_OVERLOAD_TICKS;

	// Per-motor loop state
	int          tgt_mem   [MOTORS];
	longint      integ_mem [MOTORS];
	int unsigned ovl_mem   [MOTORS];
	bit          wind_mem  [MOTORS];
	bit          fault_q = 1'b0;

	tick_t     ticks_q[$];
	loop_out_t loop_out_q[$];
	loop_out_t want;

	int  fails = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  burst_left = 1;
	bit  tick_taken = 1'b0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  rx_mode = 0;
	int  mode_left = 0;
	int  rx_beat = 0;

	initial begin
		for (int k = 0; k < MOTORS; k++) begin
			tgt_mem[k] = 0;
			integ_mem[k] = 0;
			ovl_mem[k] = 0;
			wind_mem[k] = 1'b0;
		end
	end

	// One control tick: ramp, PI with anti-windup, feedforward, clamp, overload count
	function automatic loop_out_t step_speed_loop(tick_t t);
		loop_out_t r;
		int        tg;
		int        er;
		int        mg;
		longint    ig;
		longint    ff;
		longint    tot;
		longint    drv;
		tg = tgt_mem[t.motor];
		if (t.up) begin
			if (tg != int'(t.set)) begin
				tg += int'(rstep);
				if (tg > int'(t.set))
					tg = int'(t.set);
			end
		end else if (tg != 0) begin
			tg -= int'(rstep);
			if (tg <= int'(rstep))
				tg = 0;
		end
		tgt_mem[t.motor] = tg;

		er = tg - int'(t.meas);
		mg = (er < 0) ? -er : er;
		if (mg >= int'(elim)) begin
			ovl_mem[t.motor] = (ovl_mem[t.motor] + 1) & 32'hFF;
			if (ovl_mem[t.motor] >= oticks) begin
				fault_q = 1'b1;
				ovl_mem[t.motor] = 0;
			end
		end else begin
			ovl_mem[t.motor] = 0;
		end

		// Freeze the integral while the last drive of this motor saturated
		ig = integ_mem[t.motor];
		if (!wind_mem[t.motor]) begin
			ig += er;
			if (ig > 64'sd8388607)
				ig = 64'sd8388607;
			if (ig < -64'sd8388608)
				ig = -64'sd8388608;
			integ_mem[t.motor] = ig;
		end

		ff = ((longint'(tg) * longint'(kff)) >> FRAC_W) & 64'hFFFF;
		tot = longint'(offs) * 256 + longint'(kp) * er + longint'(ki) * ig + ff * 256;
		if (tot > longint'(mxd) * 256) begin
			wind_mem[t.motor] = 1'b1;
			drv = longint'(mxd);
		end else begin
			wind_mem[t.motor] = 1'b0;
			drv = tot >>> FRAC_W;
		end
		if (drv < longint'(offs))
			drv = longint'(offs);

		r.motor = t.motor;
		r.drive = drv[DRIVE_W-1:0];
		r.target = tg[RPM_W-1:0];
		r.err = er[ERR_W-1:0];
		r.fault = fault_q;
		return r;
	endfunction

	// Take accepted ticks and predict their results
	always @(posedge clk) begin
		if (arst_n && tick_if.valid && tick_if.ready) begin
			loop_out_q.push_back(step_speed_loop(ticks_q.pop_front()));
			tick_taken = 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end
		end
	end

	// Offer ticks in bursts; hold an offer until it is taken
	always @(negedge clk) begin
		if (!(tick_if.valid && !tick_taken)) begin
			tick_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				tick_if.valid <= 1'b0;
			end else if (ticks_q.size() > 0) begin
				tick_if.valid <= 1'b1;
				tick_if.motor_select <= ticks_q[0].motor;
				tick_if.measured_rpm <= ticks_q[0].meas;
				tick_if.set_rpm <= ticks_q[0].set;
				tick_if.ramp_up <= ticks_q[0].up;
			end else begin
				tick_if.valid <= 1'b0;
			end
		end
	end

	// Result back-pressure: long hold-off on request, otherwise a shifting pattern
	always @(negedge clk) begin
		rx_beat++;
		if (hold_req) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(5, 80);
			end
			mode_left--;
			case (rx_mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= 1'($urandom_range(0, 1));
				2: res_if.ready <= ($urandom_range(0, 3) == 0);
				default: res_if.ready <= (rx_beat % 4 != 3);
			endcase
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (loop_out_q.size() == 0) begin
				$display("%0t: result with none expected: motor %0d drive %0d target %0d error %0d fault %0d",
					$time, res_if.motor_echo, res_if.drive_value, res_if.target_rpm,
					res_if.speed_error, res_if.rpm_fault);
				fails++;
			end else begin
				want = loop_out_q.pop_front();
				if (res_if.motor_echo !== want.motor || res_if.drive_value !== want.drive ||
					res_if.target_rpm !== want.target || res_if.speed_error !== want.err ||
					res_if.rpm_fault !== want.fault) begin
					$display("%0t: mismatch expected motor %0d drive %0d target %0d error %0d fault %0d",
						$time, want.motor, want.drive, want.target, want.err, want.fault);
					$display("%0t:          actual motor %0d drive %0d target %0d error %0d fault %0d",
						$time, res_if.motor_echo, res_if.drive_value, res_if.target_rpm,
						res_if.speed_error, res_if.rpm_fault);
					fails++;
				end
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_tick(logic [MOTOR_W-1:0] m, logic [RPM_W-1:0] meas,
		logic [RPM_W-1:0] set, logic up);
		ticks_q.push_back('{m, meas, set, up});
	endtask

	// Wait until every tick is taken and every result is back
	task automatic drain_loop();
		while (ticks_q.size() != 0 || loop_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_PROP_GAIN:      kp = val;
			REG_INTEG_GAIN:     ki = val;
			REG_FF_GAIN:        kff = val;
			REG_START_OFFSET:   offs = val;
			REG_RAMP_STEP:      rstep = val[RPM_W-1:0];
			REG_MAX_DRIVE:      mxd = val;
			REG_ERROR_LIMIT:    elim = val[RPM_W-1:0];
			REG_OVERLOAD_TICKS: oticks = val[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly mid-range values, with both ends now and then
	function automatic logic [CFG_DATA_W-1:0] reg_value(int unsigned hi);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return CFG_DATA_W'(hi);
			default: return CFG_DATA_W'($urandom_range(0, hi));
		endcase
	endfunction

	initial begin
		int unsigned      caps [8];
		logic [RPM_W-1:0] set_plan [MOTORS];
		int               v;
		logic [1:0]       m;
		logic             up;
		caps = '{1024, 16, 512, 2000, 600, 60000, 2000, 40};

		tick_if.valid = 1'b0;
		tick_if.motor_select = '0;
		tick_if.measured_rpm = '0;
		tick_if.set_rpm = '0;
		tick_if.ramp_up = 1'b0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_PROP_GAIN;
		cfg_if.data = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: ramp from zero, clamp at set speed, snap to zero on the way down
		queue_tick(2'd0, 14'd0, 14'h3FFF, 1'b1);
		queue_tick(2'd0, 14'd0, 14'h3FFF, 1'b1);
		queue_tick(2'd1, 14'd0, 14'd5, 1'b1);
		queue_tick(2'd2, 14'h3FFF, 14'd0, 1'b0);
		queue_tick(2'd3, 14'h3FFF, 14'h3FFF, 1'b1);
		queue_tick(2'd0, 14'd0, 14'd4, 1'b1);
		queue_tick(2'd0, 14'd0, 14'd0, 1'b0);
		drain_loop();

		// Full-scale gains and ramp step
		write_reg(REG_PROP_GAIN, 16'hFFFF);
		write_reg(REG_INTEG_GAIN, 16'hFFFF);
		write_reg(REG_FF_GAIN, 16'hFFFF);
		write_reg(REG_START_OFFSET, 16'h0000);
		write_reg(REG_RAMP_STEP, 16'h3FFF);
		write_reg(REG_MAX_DRIVE, 16'hFFFF);
		queue_tick(2'd1, 14'd0, 14'h3FFF, 1'b1);
		queue_tick(2'd1, 14'h3FFF, 14'h3FFF, 1'b0);
		queue_tick(2'd2, 14'd8000, 14'h3FFF, 1'b1);
		queue_tick(2'd2, 14'd0, 14'd100, 1'b1);
		drain_loop();

		// Zero step, zero limits, max drive under the start offset
		write_reg(REG_RAMP_STEP, 16'h0000);
		write_reg(REG_ERROR_LIMIT, 16'h0000);
		write_reg(REG_OVERLOAD_TICKS, 16'h0000);
		write_reg(REG_START_OFFSET, 16'hFFFF);
		write_reg(REG_MAX_DRIVE, 16'h0000);
		queue_tick(2'd3, 14'd5000, 14'd100, 1'b1);
		queue_tick(2'd3, 14'd0, 14'd0, 1'b0);
		queue_tick(2'd0, 14'h3FFF, 14'd0, 1'b1);
		queue_tick(2'd2, 14'h2AAA, 14'h1555, 1'b0);
		drain_loop();

		// Random settings: first all zero, then all ones, then mixed
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 8; r++)
				write_reg(cfg_reg_t'(r),
					(ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : reg_value(caps[r]));
			for (int k = 0; k < MOTORS; k++)
				set_plan[k] = RPM_W'($urandom_range(0, 16383));
			for (int i = 0; i < 25; i++) begin
				m = MOTOR_W'($urandom_range(0, 3));
				if ($urandom_range(0, 9) < 8) begin
					// Track the set speed: ramp up, then down, measured near set
					up = (i < 16) ^ ($urandom_range(0, 9) == 0);
					v = int'(set_plan[m]) + int'($urandom_range(0, 400)) - 200;
					if (v < 0)
						v = 0;
					if (v > 16383)
						v = 16383;
					if ($urandom_range(0, 15) == 0)
						set_plan[m] = RPM_W'($urandom_range(0, 16383));
					queue_tick(m, v[RPM_W-1:0], set_plan[m], up);
				end else begin
					queue_tick(m, RPM_W'($urandom_range(0, 16383)),
						RPM_W'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)));
				end
			end
			drain_loop();
		end

		// Drive motor 3's integral into its positive limit, with traffic on the others
		write_reg(REG_PROP_GAIN, 16'h0000);
		write_reg(REG_INTEG_GAIN, 16'h0001);
		write_reg(REG_FF_GAIN, 16'h0000);
		write_reg(REG_START_OFFSET, 16'h0000);
		write_reg(REG_RAMP_STEP, 16'h3FFF);
		write_reg(REG_MAX_DRIVE, 16'hFFFF);
		write_reg(REG_ERROR_LIMIT, reg_value(2000));
		write_reg(REG_OVERLOAD_TICKS, 16'h0001);
		for (int i = 0; i < 600; i++) begin
			if (i % 8 != 7)
				queue_tick(2'd3, 14'd0, 14'h3FFF, 1'b1);
			else
				queue_tick(MOTOR_W'($urandom_range(0, 2)), RPM_W'($urandom_range(0, 16383)),
					RPM_W'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)));
		end
		hold_req = 1'b1;
		drain_loop();

		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
